// ----- sv/akdc_pkg.sv -----
package akdc_pkg;

   typedef logic [2:0] key_type;

   localparam key_type KEY_NONE   = 3'd0;
   localparam key_type KEY_RIGHT  = 3'd1;
   localparam key_type KEY_UP     = 3'd2;
   localparam key_type KEY_DOWN   = 3'd3;
   localparam key_type KEY_LEFT   = 3'd4;
   localparam key_type KEY_SELECT = 3'd5;

   localparam int KEY_COUNT = 5;
   localparam int SAMPLE_W  = 10;
   localparam int TIME_W    = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_DEBOUNCE_TIME     = 3'd0;
   localparam csr_index_type REG_CHORD_WINDOW      = 3'd1;
   localparam csr_index_type REG_HYSTERESIS_MARGIN = 3'd2;
   localparam csr_index_type REG_THRESHOLD_RIGHT   = 3'd3;
   localparam csr_index_type REG_THRESHOLD_UP      = 3'd4;
   localparam csr_index_type REG_THRESHOLD_DOWN    = 3'd5;
   localparam csr_index_type REG_THRESHOLD_LEFT    = 3'd6;
   localparam csr_index_type REG_THRESHOLD_SELECT  = 3'd7;

   localparam logic       ACTION_SAMPLE = 1'b0;
   localparam logic       ACTION_CHORD  = 1'b1;

   typedef struct packed {
      logic [15:0]                         debounce_time;
      logic [15:0]                         chord_window;
      logic [7:0]                          hysteresis_margin;
      logic [KEY_COUNT-1:0][SAMPLE_W-1:0]  threshold;
   } cfg_type;

endpackage

// ----- sv/analog_keypad_debounce_chord.sv -----
// Channel   Handshake                Payload
// req       req_valid / req_ready    req_action, req_sample, req_now_ms
// rsp       rsp_valid / rsp_ready    rsp_key_event, rsp_chord_found
// csr       csr_write_enable         csr_index, csr_write_data
//
// One transfer per cycle unless the result stalls; each result is registered.
// The input register and the result register each hold one item; the key and
// chord state updates as an item moves from the first into the second.
// Synchronous reset loads the register defaults and clears all key and time state.
// A stalled result holds the result register and then the input register.
module analog_keypad_debounce_chord
   import akdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [TIME_W-1:0]     req_now_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output key_type               rsp_key_event,
   output logic                  rsp_chord_found,
   input  logic                  csr_write_enable,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type           cfg;
   logic              in_valid_ff;
   logic              action_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [TIME_W-1:0] now_ms_ff;
   logic              out_valid_ff;
   key_type           key_event_ff;
   logic              chord_found_ff;
   logic              out_take;
   logic              step;
   key_type           raw_key;
   key_type           stable_key;
   key_type           key_event_in;
   logic              chord_found_in;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_take;
   assign req_ready = !in_valid_ff || out_take;

   akdc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   akdc_decode u_decode (
      .cfg        (cfg),
      .sample     (sample_ff),
      .stable_key (stable_key),
      .raw_key    (raw_key)
   );

   akdc_track u_track (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .step        (step),
      .action      (action_ff),
      .now_ms      (now_ms_ff),
      .raw_key     (raw_key),
      .stable_key  (stable_key),
      .key_event   (key_event_in),
      .chord_found (chord_found_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         action_ff <= req_action;
         sample_ff <= req_sample;
         now_ms_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff <= in_valid_ff;
      end
      if (step) begin
         key_event_ff   <= key_event_in;
         chord_found_ff <= chord_found_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_key_event   = key_event_ff;
   assign rsp_chord_found = chord_found_ff;

   a_event_or_chord: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(chord_found_ff && (key_event_ff != KEY_NONE)))
      else $error("result carries both a key event and a chord");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (key_event_ff <= KEY_SELECT))
      else $error("key event out of range");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_take) |=> (in_valid_ff && $stable(now_ms_ff)))
      else $error("pending item dropped while result stalled");

   a_no_step_when_full: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(key_event_ff)))
      else $error("stalled result overwritten");

endmodule

// ----- sv/akdc_csr.sv -----
module akdc_csr
   import akdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time     <= 16'd60;
         cfg_ff.chord_window      <= 16'd750;
         cfg_ff.hysteresis_margin <= 8'd30;
         cfg_ff.threshold[0]      <= 10'd50;
         cfg_ff.threshold[1]      <= 10'd150;
         cfg_ff.threshold[2]      <= 10'd350;
         cfg_ff.threshold[3]      <= 10'd550;
         cfg_ff.threshold[4]      <= 10'd800;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DEBOUNCE_TIME:     cfg_ff.debounce_time     <= csr_write_data;
            REG_CHORD_WINDOW:      cfg_ff.chord_window      <= csr_write_data;
            REG_HYSTERESIS_MARGIN: cfg_ff.hysteresis_margin <= csr_write_data[7:0];
            REG_THRESHOLD_RIGHT:   cfg_ff.threshold[0] <= csr_write_data[SAMPLE_W-1:0];
            REG_THRESHOLD_UP:      cfg_ff.threshold[1] <= csr_write_data[SAMPLE_W-1:0];
            REG_THRESHOLD_DOWN:    cfg_ff.threshold[2] <= csr_write_data[SAMPLE_W-1:0];
            REG_THRESHOLD_LEFT:    cfg_ff.threshold[3] <= csr_write_data[SAMPLE_W-1:0];
            REG_THRESHOLD_SELECT:  cfg_ff.threshold[4] <= csr_write_data[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/akdc_decode.sv -----
module akdc_decode
   import akdc_pkg::*;
(
   input  cfg_type             cfg,
   input  logic [SAMPLE_W-1:0] sample,
   input  key_type             stable_key,
   output key_type             raw_key
);

   logic [KEY_COUNT-1:0]              below;
   logic [KEY_COUNT-1:0][SAMPLE_W:0]  limit;

   always_comb begin
      for (int k = 0; k < KEY_COUNT; k++) begin
         limit[k] = {1'b0, cfg.threshold[k]}
                  + ((stable_key == key_type'(k + 1))
                     ? {{(SAMPLE_W - 7){1'b0}}, cfg.hysteresis_margin}
                     : {(SAMPLE_W + 1){1'b0}});
         below[k] = {1'b0, sample} < limit[k];
      end
   end

   always_comb begin
      raw_key = KEY_NONE;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (below[k]) begin
            raw_key = key_type'(k + 1);
         end
      end
   end

endmodule

// ----- sv/akdc_track.sv -----
module akdc_track
   import akdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              step,
   input  logic              action,
   input  logic [TIME_W-1:0] now_ms,
   input  key_type           raw_key,
   output key_type           stable_key,
   output key_type           key_event,
   output logic              chord_found
);

   key_type           raw_key_ff;
   key_type           stable_key_ff;
   key_type           reported_key_ff;
   logic [TIME_W-1:0] change_time_ff;
   logic [TIME_W-1:0] right_press_time_ff;
   logic [TIME_W-1:0] select_press_time_ff;
   logic [TIME_W-1:0] chord_time_ff;

   logic              raw_changed;
   logic [TIME_W-1:0] since_change;
   logic              settled;
   key_type           stable_key_in;
   key_type           press_key;
   logic              both_pressed;
   logic [TIME_W-1:0] press_gap;
   logic [TIME_W-1:0] since_chord;
   logic              chord_hit;

   assign raw_changed  = raw_key != raw_key_ff;
   assign since_change = now_ms - change_time_ff;
   assign settled      = raw_changed ? (cfg.debounce_time == 16'd0)
                                     : (since_change >= {16'd0, cfg.debounce_time});
   assign stable_key_in = settled ? raw_key : stable_key_ff;
   assign press_key = ((stable_key_in != reported_key_ff) && (stable_key_in != KEY_NONE))
                      ? stable_key_in : KEY_NONE;

   assign both_pressed = (right_press_time_ff != '0) && (select_press_time_ff != '0);
   assign press_gap    = (right_press_time_ff > select_press_time_ff)
                         ? right_press_time_ff - select_press_time_ff
                         : select_press_time_ff - right_press_time_ff;
   assign since_chord  = now_ms - chord_time_ff;
   assign chord_hit    = both_pressed
                         && (press_gap <= {16'd0, cfg.chord_window})
                         && (since_chord > {16'd0, cfg.chord_window});

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_key_ff           <= KEY_NONE;
         stable_key_ff        <= KEY_NONE;
         reported_key_ff      <= KEY_NONE;
         change_time_ff       <= '0;
         right_press_time_ff  <= '0;
         select_press_time_ff <= '0;
         chord_time_ff        <= '0;
      end else if (step) begin
         if (action == ACTION_SAMPLE) begin
            raw_key_ff      <= raw_key;
            stable_key_ff   <= stable_key_in;
            reported_key_ff <= stable_key_in;
            if (raw_changed) begin
               change_time_ff <= now_ms;
            end
            if (press_key == KEY_RIGHT) begin
               right_press_time_ff <= now_ms;
            end
            if (press_key == KEY_SELECT) begin
               select_press_time_ff <= now_ms;
            end
         end else if (chord_hit) begin
            chord_time_ff        <= now_ms;
            right_press_time_ff  <= '0;
            select_press_time_ff <= '0;
         end
      end
   end

   assign stable_key  = stable_key_ff;
   assign key_event   = (action == ACTION_SAMPLE) ? press_key : KEY_NONE;
   assign chord_found = (action == ACTION_CHORD) && chord_hit;

endmodule
